// File: hdl/cmsr_pkg.sv
// Shared types and constants for the segmented CAN message reassembler.
// No dependencies; used by every file in hdl.
package cmsr_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int NBANK     = 8;
  localparam int ROWS      = (BUF_BYTES + NBANK - 1) / NBANK;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WPOS_W    = 13;
  localparam int POS_W     = 14;
  localparam int LEN_W     = 12;
  localparam int IDX_W     = 12;

  localparam logic [POS_W-1:0]  BUF_END   = POS_W'(BUF_BYTES);
  localparam logic [WPOS_W-1:0] WPOS_MAX  = 13'h1FFF;
  localparam logic [WPOS_W-1:0] WPOS_FF   = 13'd5;
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

  localparam logic [1:0] CMD_FRAME   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [3:0] FT_SINGLE = 4'd0;
  localparam logic [3:0] FT_FIRST  = 4'd1;
  localparam logic [3:0] FT_CONSEC = 4'd2;

  localparam logic [2:0] CODE_BUSY     = 3'd0;
  localparam logic [2:0] CODE_COMPLETE = 3'd1;
  localparam logic [2:0] CODE_XFER     = 3'd2;
  localparam logic [2:0] CODE_ERROR    = 3'd3;
  localparam logic [2:0] CODE_DONE     = 3'd4;
  localparam logic [2:0] CODE_NONE     = 3'd5;

  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_SEP_TIME   = 1'b1;

  localparam logic [4:0] BS_RESET = 5'd8;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       frame_id;
    logic [3:0]       frame_length;
    logic [7:0]       data_byte_0;
    logic [7:0]       data_byte_1;
    logic [7:0]       data_byte_2;
    logic [7:0]       data_byte_3;
    logic [7:0]       data_byte_4;
    logic [7:0]       data_byte_5;
    logic [7:0]       data_byte_6;
    logic [7:0]       data_byte_7;
    logic [IDX_W-1:0] read_index;
  } cmsr_in_t;

  typedef struct packed {
    logic [2:0]       code;
    logic             fc_request;
    logic [7:0]       fc_dest_id;
    logic [7:0]       fc_source_addr;
    logic [4:0]       fc_block_size;
    logic [7:0]       fc_sep_time;
    logic             msg_ready;
    logic [7:0]       msg_sender;
    logic [7:0]       msg_receiver;
    logic [LEN_W-1:0] msg_length;
    logic [7:0]       read_byte;
  } cmsr_out_t;

  // byte run written from one frame; bytes[0] lands at base
  typedef struct packed {
    logic                  en;
    logic [POS_W-1:0]      base;
    logic [2:0]            cnt;
    logic [NBANK-1:0][7:0] bytes;
  } cmsr_wreq_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } cmsr_rreq_t;

endpackage

// File: hdl/cmsr_store.sv
// Banked message store: eight byte-wide banks, one frame's bytes per cycle outside
// a sweep, registered byte read and a row-by-row clearing sweep. Uses cmsr_pkg.
module cmsr_store (
  input  logic                clk,
  input  logic                rst_n,
  input  cmsr_pkg::cmsr_wreq_t wreq,
  input  cmsr_pkg::cmsr_rreq_t rreq,
  input  logic                clr_start,
  output logic                clr_busy,
  output logic [7:0]          rd_data
);

  logic                          clr_r;
  logic [cmsr_pkg::ROW_W-1:0]    clr_row_r;
  logic [2:0]                    rd_sel_r;
  logic [cmsr_pkg::NBANK-1:0][7:0] bank_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_row_r <= '0;
    end else if (clr_start) begin
      clr_r     <= 1'b1;
      clr_row_r <= '0;
    end else if (clr_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (clr_row_r == cmsr_pkg::ROW_LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rreq.en) begin
      rd_sel_r <= rreq.addr[2:0];
    end
  end

  for (genvar b = 0; b < cmsr_pkg::NBANK; b++) begin : g_bank
    logic [7:0]                 mem [cmsr_pkg::ROWS];
    logic [7:0]                 q_r;
    logic [2:0]                 off;
    logic [cmsr_pkg::POS_W-1:0] pos;
    logic                       lane_en;

    always_comb begin
      off     = 3'(b) - wreq.base[2:0];
      pos     = wreq.base + cmsr_pkg::POS_W'(off);
      lane_en = wreq.en && (off < wreq.cnt) && (pos < cmsr_pkg::BUF_END);
    end

    always_ff @(posedge clk) begin
      if (clr_r) begin
        mem[clr_row_r] <= 8'h00;
      end else if (lane_en) begin
        mem[pos[cmsr_pkg::ROW_W+2:3]] <= wreq.bytes[off];
      end
      if (rreq.en) begin
        q_r <= mem[rreq.addr[cmsr_pkg::ROW_W+2:3]];
      end
    end

    assign bank_q[b] = q_r;
  end

  assign clr_busy = clr_r;
  assign rd_data  = bank_q[rd_sel_r];

endmodule

// File: hdl/can_segmented_message_reassembler_top.sv
// Segmented CAN message reassembler, top level: frame decode, transfer
// state, result pipeline and output register. Uses cmsr_pkg, cmsr_store.
// Results pass through the result stage, then the output register. Throughput:
// one request per cycle unless the output is stalled; the store takes a frame's
// bytes in one write. Reset and each release start a clearing sweep (one store row
// per cycle) during which no request is taken; config writes are always taken.
module can_segmented_message_reassembler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmsr_pkg::cmsr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cmsr_pkg::cmsr_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [7:0]          cfg_wdata
);

  logic [4:0]                  bs_r;
  logic [7:0]                  st_r;
  logic [7:0]                  snd_r, snd_nxt;
  logic [7:0]                  rcv_r, rcv_nxt;
  logic [cmsr_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [cmsr_pkg::WPOS_W-1:0] wp_r, wp_nxt;
  logic                        busy_r, busy_nxt;
  logic                        rdy_r, rdy_nxt;

  logic                        s1_v_r, s1_rd_r, s1_rd_nxt;
  cmsr_pkg::cmsr_out_t         s1_r, s1_nxt;
  logic                        out_v_r;
  cmsr_pkg::cmsr_out_t         out_r;

  cmsr_pkg::cmsr_wreq_t        wreq;
  cmsr_pkg::cmsr_rreq_t        rreq;
  logic                        clr_start, clr_busy;
  logic [7:0]                  rd_data;
  logic                        in_acc, s1_move;

  logic [3:0]                  flen, ftype, nib;
  logic [2:0]                  cnt2, cnt3;
  logic [7:0][7:0]             dat;
  logic [cmsr_pkg::POS_W-1:0]  wsum;
  logic                        rel_ok, fc;
  logic [2:0]                  code;

  assign s1_move  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = clr_busy || (s1_v_r && out_v_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    flen  = (in_data.frame_length > 4'd8) ? 4'd8 : in_data.frame_length;
    ftype = in_data.data_byte_1[7:4];
    nib   = in_data.data_byte_1[3:0];
    dat   = {in_data.data_byte_7, in_data.data_byte_6, in_data.data_byte_5,
             in_data.data_byte_4, in_data.data_byte_3, in_data.data_byte_2,
             in_data.data_byte_1, in_data.data_byte_0};
    cnt2  = (flen > 4'd2) ? 3'(flen - 4'd2) : 3'd0;
    cnt3  = (flen > 4'd3) ? 3'(flen - 4'd3) : 3'd0;
    wsum  = {1'b0, wp_r} + cmsr_pkg::POS_W'(cnt2);

    snd_nxt   = snd_r;
    rcv_nxt   = rcv_r;
    len_nxt   = len_r;
    wp_nxt    = wp_r;
    busy_nxt  = busy_r;
    rdy_nxt   = rdy_r;
    code      = cmsr_pkg::CODE_ERROR;
    fc        = 1'b0;
    rel_ok    = 1'b0;
    clr_start = 1'b0;
    s1_rd_nxt = 1'b0;
    wreq      = '0;
    wreq.bytes = dat >> 16;
    rreq.en   = 1'b0;
    rreq.addr = in_data.read_index;

    unique case (in_data.cmd)
      cmsr_pkg::CMD_FRAME: begin
        case (ftype)
          cmsr_pkg::FT_SINGLE: begin
            if (busy_r) begin
              code = cmsr_pkg::CODE_BUSY;
            end else begin
              snd_nxt  = in_data.data_byte_0;
              rcv_nxt  = in_data.frame_id;
              len_nxt  = cmsr_pkg::LEN_W'(nib);
              wreq.en  = 1'b1;
              wreq.cnt = ({1'b0, cnt2} > nib) ? nib[2:0] : cnt2;
              rdy_nxt  = 1'b1;
              code     = cmsr_pkg::CODE_COMPLETE;
            end
          end
          cmsr_pkg::FT_FIRST: begin
            if (busy_r) begin
              code = cmsr_pkg::CODE_BUSY;
            end else begin
              busy_nxt   = 1'b1;
              wp_nxt     = cmsr_pkg::WPOS_FF;
              snd_nxt    = in_data.data_byte_0;
              rcv_nxt    = in_data.frame_id;
              len_nxt    = {nib, in_data.data_byte_2};
              wreq.en    = 1'b1;
              wreq.cnt   = cnt3;
              wreq.bytes = dat >> 24;
              fc         = 1'b1;
              code       = cmsr_pkg::CODE_XFER;
            end
          end
          cmsr_pkg::FT_CONSEC: begin
            if (busy_r) begin
              wreq.en   = 1'b1;
              wreq.base = {1'b0, wp_r};
              wreq.cnt  = cnt2;
              wp_nxt    = (wsum > {1'b0, cmsr_pkg::WPOS_MAX}) ? cmsr_pkg::WPOS_MAX
                                                               : wsum[cmsr_pkg::WPOS_W-1:0];
              if (wp_nxt >= {1'b0, len_r}) begin
                rdy_nxt = 1'b1;
                code    = cmsr_pkg::CODE_COMPLETE;
              end else begin
                fc   = (({1'b0, nib} + 5'd1) == bs_r);
                code = cmsr_pkg::CODE_XFER;
              end
            end
          end
          default: code = cmsr_pkg::CODE_ERROR;
        endcase
      end
      cmsr_pkg::CMD_READ: begin
        if (rdy_r) begin
          code      = cmsr_pkg::CODE_DONE;
          rreq.en   = in_data.read_index < cmsr_pkg::IDX_W'(cmsr_pkg::BUF_BYTES - 1)
                      || in_data.read_index == cmsr_pkg::IDX_W'(cmsr_pkg::BUF_BYTES - 1);
          s1_rd_nxt = rreq.en;
        end else begin
          code = cmsr_pkg::CODE_NONE;
        end
      end
      cmsr_pkg::CMD_RELEASE: begin
        if (rdy_r) begin
          rel_ok    = 1'b1;
          clr_start = 1'b1;
          snd_nxt   = '0;
          rcv_nxt   = '0;
          len_nxt   = '0;
          wp_nxt    = '0;
          busy_nxt  = 1'b0;
          rdy_nxt   = 1'b0;
          code      = cmsr_pkg::CODE_DONE;
        end else begin
          code = cmsr_pkg::CODE_NONE;
        end
      end
      default: code = cmsr_pkg::CODE_ERROR;
    endcase

    wreq.en   = wreq.en && in_acc;
    rreq.en   = rreq.en && in_acc;
    clr_start = clr_start && in_acc;

    s1_nxt                = '0;
    s1_nxt.code           = code;
    s1_nxt.fc_request     = fc;
    if (fc) begin
      s1_nxt.fc_dest_id     = in_data.data_byte_0;
      s1_nxt.fc_source_addr = in_data.frame_id;
      s1_nxt.fc_block_size  = bs_r;
      s1_nxt.fc_sep_time    = st_r;
    end
    if (rel_ok) begin
      s1_nxt.msg_ready    = 1'b1;
      s1_nxt.msg_sender   = snd_r;
      s1_nxt.msg_receiver = rcv_r;
      s1_nxt.msg_length   = len_r;
    end else if (rdy_nxt) begin
      s1_nxt.msg_ready    = 1'b1;
      s1_nxt.msg_sender   = snd_nxt;
      s1_nxt.msg_receiver = rcv_nxt;
      s1_nxt.msg_length   = len_nxt;
    end
  end

  cmsr_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wreq      (wreq),
    .rreq      (rreq),
    .clr_start (clr_start),
    .clr_busy  (clr_busy),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= cmsr_pkg::BS_RESET;
      st_r <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cmsr_pkg::CFG_BLOCK_SIZE: bs_r <= cfg_wdata[4:0];
        cmsr_pkg::CFG_SEP_TIME:   st_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snd_r  <= '0;
      rcv_r  <= '0;
      len_r  <= '0;
      wp_r   <= '0;
      busy_r <= 1'b0;
      rdy_r  <= 1'b0;
    end else if (in_acc) begin
      snd_r  <= snd_nxt;
      rcv_r  <= rcv_nxt;
      len_r  <= len_nxt;
      wp_r   <= wp_nxt;
      busy_r <= busy_nxt;
      rdy_r  <= rdy_nxt;
    end
  end

  // result stage then output register; read byte joins on the way out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc || (s1_v_r && !s1_move);
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r    <= s1_nxt;
      s1_rd_r <= s1_rd_nxt;
    end
    if (s1_move) begin
      out_r           <= s1_r;
      out_r.read_byte <= s1_rd_r ? rd_data : 8'h00;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: hdl/cmsr_checker.sv
// Port-level checks for the reassembler top level, attached by bind.
// Uses cmsr_pkg.
module cmsr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input cmsr_pkg::cmsr_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fc_request |->
      out_data.fc_dest_id == 8'h00 && out_data.fc_source_addr == 8'h00 &&
      out_data.fc_block_size == 5'd0 && out_data.fc_sep_time == 8'h00)
    else $error("flow-control fields set without request");

  a_fc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fc_request |-> out_data.code == cmsr_pkg::CODE_XFER)
    else $error("flow-control request outside transfer");

  a_msg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.msg_ready |->
      out_data.msg_sender == 8'h00 && out_data.msg_receiver == 8'h00 &&
      out_data.msg_length == '0)
    else $error("message fields set with nothing held");

  a_rd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_byte != 8'h00 |->
      out_data.code == cmsr_pkg::CODE_DONE && out_data.msg_ready)
    else $error("read byte without finished read");

endmodule

bind can_segmented_message_reassembler_top cmsr_checker u_cmsr_checker (.*);
